@@ hw/rtl/albt_pkg.sv @@
// Shared types, widths, operation codes and register indexes of the loop buffer tap.
// Used by albt_ctrl, albt_datapath and audio_loop_buffer_tap; depends on nothing.
`default_nettype none

package albt_pkg;

   // store geometry
   localparam int DEPTH      = 65536;
   localparam int ADDR_W     = $clog2(DEPTH);

   // field and register widths
   localparam int OP_W       = 3;
   localparam int SAMPLE_W   = 32;
   localparam int POS_W      = 16;
   localparam int LOOP_W     = 17;
   localparam int INC_W      = 17;
   localparam int RATE_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // effective loop length holds 1..DEPTH
   localparam int DEPTH_W    = $clog2(DEPTH + 1);
   localparam int EFF_W      = (LOOP_W > DEPTH_W) ? LOOP_W : DEPTH_W;

   // modulo unit: dividend is tap plus increment or a set position, one bit per step
   localparam int SUM_W      = (ADDR_W > INC_W) ? ADDR_W : INC_W;
   localparam int DIV_W      = SUM_W + 1;
   localparam int STEP_W     = $clog2(DIV_W);

   // register reset values
   localparam logic [CSR_DATA_W-1:0] LOOP_RESET = CSR_DATA_W'(65536);
   localparam logic [INC_W-1:0]      INC_RESET  = INC_W'(1);
   localparam logic [RATE_W-1:0]     RATE_RESET = RATE_W'(1);

   // operation codes
   localparam logic [OP_W-1:0] OP_READ    = 3'd0;
   localparam logic [OP_W-1:0] OP_WRITE   = 3'd1;
   localparam logic [OP_W-1:0] OP_MIX     = 3'd2;
   localparam logic [OP_W-1:0] OP_ADD     = 3'd3;
   localparam logic [OP_W-1:0] OP_ADVANCE = 3'd4;
   localparam logic [OP_W-1:0] OP_SET_POS = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_LENGTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INCREMENT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_DIVISOR = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRE_LEVEL    = 2'd3;

   typedef enum logic [3:0] {
      CTL_CLEAR,
      CTL_IDLE,
      CTL_FETCH,
      CTL_MUL,
      CTL_STORE,
      CTL_REPLY,
      CTL_WRITE,
      CTL_ADVANCE,
      CTL_DIVIDE,
      CTL_TAP_LOAD
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic fetch;
      logic mul;
      logic store;
      logic use_product;
      logic write_sample;
      logic advance;
      logic div_load_adv;
      logic div_load_pos;
      logic div_step;
      logic tap_load;
      logic clear_write;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_hit;
      logic div_last;
      logic clear_last;
   } status_type;

   // map a loop_length write onto the length the tap really cycles through
   function automatic logic [EFF_W-1:0] eff_loop(input logic [CSR_DATA_W-1:0] value);
      logic [LOOP_W-1:0] len;
      len = value[LOOP_W-1:0];
      if (len == '0 || 64'(len) > 64'(DEPTH)) begin
         return EFF_W'(DEPTH);
      end
      return EFF_W'(len);
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/albt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module albt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, hold data while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/albt_ctrl.sv @@
// Sequencer of the loop buffer tap: clearing pass, operation decode and step order.
// Depends on albt_pkg for state, command and status types and operation codes.
`default_nettype none

module albt_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_start,
   input  wire logic [albt_pkg::OP_W-1:0]   req_operation,
   input  wire albt_pkg::status_type        status,
   output albt_pkg::cmd_type                cmd,
   output logic                             busy,
   output logic                             rsp_valid
);

   albt_pkg::ctl_state_type state_ff, state_in;
   logic [albt_pkg::OP_W-1:0] op_ff, op_in;

   // state and operation registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= albt_pkg::CTL_CLEAR;
         op_ff    <= albt_pkg::OP_READ;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         albt_pkg::CTL_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (status.clear_last) begin
               state_in = albt_pkg::CTL_IDLE;
            end
         end
         albt_pkg::CTL_IDLE: begin
            busy = 1'b0;
            if (req_start) begin
               cmd.accept = 1'b1;
               op_in      = req_operation;
               case (req_operation)
                  albt_pkg::OP_READ,
                  albt_pkg::OP_MIX,
                  albt_pkg::OP_ADD:     state_in = albt_pkg::CTL_FETCH;
                  albt_pkg::OP_WRITE:   state_in = albt_pkg::CTL_WRITE;
                  albt_pkg::OP_ADVANCE: state_in = albt_pkg::CTL_ADVANCE;
                  albt_pkg::OP_SET_POS: begin
                     cmd.div_load_pos = 1'b1;
                     state_in         = albt_pkg::CTL_DIVIDE;
                  end
                  default:              state_in = albt_pkg::CTL_IDLE;
               endcase
            end
         end
         albt_pkg::CTL_FETCH: begin
            cmd.fetch = 1'b1;
            if (op_ff == albt_pkg::OP_MIX) begin
               state_in = albt_pkg::CTL_MUL;
            end else if (op_ff == albt_pkg::OP_ADD) begin
               state_in = albt_pkg::CTL_STORE;
            end else begin
               state_in = albt_pkg::CTL_REPLY;
            end
         end
         albt_pkg::CTL_MUL: begin
            cmd.mul  = 1'b1;
            state_in = albt_pkg::CTL_STORE;
         end
         albt_pkg::CTL_STORE: begin
            cmd.store       = 1'b1;
            cmd.use_product = (op_ff == albt_pkg::OP_MIX);
            state_in        = albt_pkg::CTL_IDLE;
         end
         albt_pkg::CTL_REPLY: begin
            rsp_valid = 1'b1;
            state_in  = albt_pkg::CTL_IDLE;
         end
         albt_pkg::CTL_WRITE: begin
            cmd.write_sample = 1'b1;
            state_in         = albt_pkg::CTL_IDLE;
         end
         albt_pkg::CTL_ADVANCE: begin
            cmd.advance = 1'b1;
            if (status.count_hit) begin
               cmd.div_load_adv = 1'b1;
               state_in         = albt_pkg::CTL_DIVIDE;
            end else begin
               state_in = albt_pkg::CTL_IDLE;
            end
         end
         albt_pkg::CTL_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = albt_pkg::CTL_TAP_LOAD;
            end
         end
         albt_pkg::CTL_TAP_LOAD: begin
            cmd.tap_load = 1'b1;
            state_in     = albt_pkg::CTL_IDLE;
         end
         default: begin
            state_in = albt_pkg::CTL_IDLE;
         end
      endcase
   end

   // reset always restarts the clearing pass
   assert property (@(posedge clock) reset |=> state_ff == albt_pkg::CTL_CLEAR)
      else $error("reset did not start the clearing pass");

   // a result word is shown for one cycle and the block then returns to idle
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid |=> !rsp_valid && state_ff == albt_pkg::CTL_IDLE)
      else $error("result strobe not followed by idle");

endmodule

`default_nettype wire

@@ hw/rtl/albt_datapath.sv @@
// Datapath of the loop buffer tap: registers, tap and divide counter, Q31 mix,
// saturating add, bit-serial modulo unit and the sample store.
// Depends on albt_pkg and albt_ram.
`default_nettype none

module albt_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire albt_pkg::cmd_type                 cmd,
   output albt_pkg::status_type                   status,
   input  wire logic [albt_pkg::SAMPLE_W-1:0]     req_sample,
   input  wire logic [albt_pkg::POS_W-1:0]        req_position,
   input  wire logic                              csr_we,
   input  wire logic [albt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [albt_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic      [albt_pkg::SAMPLE_W-1:0]     rsp_read_sample
);

   localparam int SW = albt_pkg::SAMPLE_W;

   // configuration
   logic [albt_pkg::EFF_W-1:0]  eff_loop_ff;
   logic [albt_pkg::INC_W-1:0]  increment_ff;
   logic [albt_pkg::RATE_W-1:0] rate_div_ff;
   logic signed [SW-1:0]        pre_level_ff;

   // state
   logic [albt_pkg::ADDR_W-1:0] tap_ff;
   logic [albt_pkg::RATE_W-1:0] count_ff;
   logic [albt_pkg::RATE_W-1:0] count_in;
   logic [albt_pkg::ADDR_W-1:0] clr_ff;

   // operands and arithmetic
   logic signed [SW-1:0]        sample_ff;
   logic signed [2*SW-1:0]      product_ff;
   logic signed [SW:0]          product_q;
   logic signed [SW-1:0]        product_sat;
   logic signed [SW-1:0]        operand;
   logic signed [SW:0]          sum;
   logic signed [SW-1:0]        sum_sat;

   // modulo unit
   logic [albt_pkg::EFF_W-1:0]  rem_ff;
   logic [albt_pkg::DIV_W-1:0]  dvd_ff;
   logic [albt_pkg::STEP_W-1:0] step_ff;
   logic [albt_pkg::EFF_W:0]    rem_shift;
   logic [albt_pkg::EFF_W:0]    rem_diff;
   logic [albt_pkg::DIV_W-1:0]  adv_sum;

   // store ports
   logic                        ram_wr_en;
   logic [albt_pkg::ADDR_W-1:0] ram_wr_addr;
   logic [SW-1:0]               ram_wr_data;
   logic [SW-1:0]               ram_rd_data;

   // configuration writes; a divisor write also clears the divide counter
   always_ff @(posedge clock) begin
      if (reset) begin
         eff_loop_ff  <= albt_pkg::eff_loop(albt_pkg::LOOP_RESET);
         increment_ff <= albt_pkg::INC_RESET;
         rate_div_ff  <= albt_pkg::RATE_RESET;
         pre_level_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            albt_pkg::CSR_LOOP_LENGTH:  eff_loop_ff  <= albt_pkg::eff_loop(csr_wdata);
            albt_pkg::CSR_INCREMENT:    increment_ff <= csr_wdata[albt_pkg::INC_W-1:0];
            albt_pkg::CSR_RATE_DIVISOR: rate_div_ff  <= csr_wdata[albt_pkg::RATE_W-1:0];
            albt_pkg::CSR_PRE_LEVEL:    pre_level_ff <= signed'(csr_wdata[SW-1:0]);
            default: ;
         endcase
      end
   end

   // divide counter
   assign count_in         = count_ff + 1'b1;
   assign status.count_hit = (count_in >= rate_div_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_we && csr_index == albt_pkg::CSR_RATE_DIVISOR) begin
         count_ff <= '0;
      end else if (cmd.advance) begin
         count_ff <= status.count_hit ? '0 : count_in;
      end
   end

   // tap position
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0;
      end else if (cmd.tap_load) begin
         tap_ff <= rem_ff[albt_pkg::ADDR_W-1:0];
      end
   end

   // clearing pass address
   assign status.clear_last = (clr_ff == albt_pkg::ADDR_W'(albt_pkg::DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_write) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // hold the sample of the accepted word
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= signed'(req_sample);
      end
   end

   // Q31 product of old contents and gain
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         product_ff <= signed'(ram_rd_data) * pre_level_ff;
      end
   end

   // floor shift by 31, then clamp the single overflow case
   assign product_q   = product_ff[2*SW-1:SW-1];
   assign product_sat = (!product_q[SW] && product_q[SW-1]) ?
                        {1'b0, {(SW-1){1'b1}}} : product_q[SW-1:0];

   // saturating add of the input sample
   assign operand = cmd.use_product ? product_sat : signed'(ram_rd_data);
   assign sum     = {operand[SW-1], operand} + {sample_ff[SW-1], sample_ff};
   always_comb begin
      if (sum[SW] != sum[SW-1]) begin
         sum_sat = sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end else begin
         sum_sat = sum[SW-1:0];
      end
   end

   // modulo unit: restoring remainder, one dividend bit per step
   assign adv_sum   = albt_pkg::DIV_W'(tap_ff) + albt_pkg::DIV_W'(increment_ff);
   assign rem_shift = {rem_ff, dvd_ff[albt_pkg::DIV_W-1]};
   assign rem_diff  = rem_shift - {1'b0, eff_loop_ff};
   assign status.div_last = (step_ff == albt_pkg::STEP_W'(albt_pkg::DIV_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.div_load_adv || cmd.div_load_pos) begin
         step_ff <= '0;
      end else if (cmd.div_step) begin
         step_ff <= step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load_adv) begin
         rem_ff <= '0;
         dvd_ff <= adv_sum;
      end else if (cmd.div_load_pos) begin
         rem_ff <= '0;
         dvd_ff <= albt_pkg::DIV_W'(req_position);
      end else if (cmd.div_step) begin
         if (rem_shift >= {1'b0, eff_loop_ff}) begin
            rem_ff <= rem_diff[albt_pkg::EFF_W-1:0];
         end else begin
            rem_ff <= rem_shift[albt_pkg::EFF_W-1:0];
         end
         dvd_ff <= {dvd_ff[albt_pkg::DIV_W-2:0], 1'b0};
      end
   end

   // store write select
   assign ram_wr_en   = cmd.clear_write || cmd.write_sample || cmd.store;
   assign ram_wr_addr = cmd.clear_write ? clr_ff : tap_ff;
   always_comb begin
      if (cmd.clear_write) begin
         ram_wr_data = '0;
      end else if (cmd.write_sample) begin
         ram_wr_data = sample_ff;
      end else begin
         ram_wr_data = sum_sat;
      end
   end

   albt_ram #(
      .WIDTH (SW),
      .DEPTH (albt_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.fetch),
      .rd_addr (tap_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_read_sample = ram_rd_data;

   // the effective loop length always lies in 1..DEPTH
   assert property (@(posedge clock) disable iff (reset)
                    eff_loop_ff != '0 &&
                    64'(eff_loop_ff) <= 64'(albt_pkg::DEPTH))
      else $error("effective loop length out of range");

   // every modulo step leaves a remainder below the loop length
   assert property (@(posedge clock) disable iff (reset)
                    cmd.div_step |=> rem_ff < eff_loop_ff)
      else $error("modulo remainder not below loop length");

   // neither a set position nor an advance reloads the modulo unit during a divide
   assert property (@(posedge clock) disable iff (reset)
                    cmd.div_step |-> !cmd.div_load_pos && !cmd.div_load_adv)
      else $error("modulo unit reloaded during a divide");

endmodule

`default_nettype wire

@@ hw/rtl/audio_loop_buffer_tap.sv @@
// Loop buffer tap: one tap position over a 65536-word Q31 sample store.
//
// Command channel: a word is taken on a rising edge with req_start high and
// busy low; req_operation picks read, write, mix, add, advance or set position,
// req_sample and req_position are its operands. Only a read gives a result:
// rsp_read_sample is valid for the single cycle rsp_valid is high, in the reply
// state that follows the fetch state. The receiver cannot stall the block.
// Steps from acceptance back to busy low: read fetches and replies; write
// stores; add fetches, adds with saturation and writes back; mix does fetch,
// Q31 multiply, saturating add and write back; an advance that moves the tap,
// and a set position, run the bit-serial modulo unit, which retires one of 18
// dividend bits per cycle, then load the tap. Unused codes return to idle.
// Configuration: csr_we writes csr_wdata to the register at csr_index
// (loop length, increment, rate divisor, pre level) at once; the user is to
// write only while idle; the block does not enforce it. Reset: a synchronous
// reset restores the registers, zeroes tap and divide counter, then clears
// the store one word per cycle, busy held high; configuration writes are taken.
// Depends on albt_pkg, albt_ctrl, albt_datapath and albt_ram.
`default_nettype none

module audio_loop_buffer_tap (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_start,
   output logic                                   busy,
   input  wire logic [albt_pkg::OP_W-1:0]         req_operation,
   input  wire logic [albt_pkg::SAMPLE_W-1:0]     req_sample,
   input  wire logic [albt_pkg::POS_W-1:0]        req_position,
   output logic                                   rsp_valid,
   output logic      [albt_pkg::SAMPLE_W-1:0]     rsp_read_sample,
   input  wire logic                              csr_we,
   input  wire logic [albt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [albt_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   albt_pkg::cmd_type    cmd;
   albt_pkg::status_type status;

   albt_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_start     (req_start),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy),
      .rsp_valid     (rsp_valid)
   );

   albt_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sample      (req_sample),
      .req_position    (req_position),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_read_sample (rsp_read_sample)
   );

endmodule

`default_nettype wire
